>>> design/swss_pkg.sv
// Shared types and codes for the sliding-window sender with selective ack.
// Used by the controller, the datapath and the top level; depends on nothing.
package swss_pkg;

    // Event codes carried on the op field.
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Result kinds carried on the kind field.
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_FAILED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_TOTAL     = 2'd1;
    localparam logic [1:0] REG_MAX_TO    = 2'd2;
    localparam logic [1:0] REG_DUP_THR   = 2'd3;

    // Follow-up work decided while an event is applied to the state.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_BURST,
        ACT_CHECK,
        ACT_FAIL
    } act_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       eval;
        logic       check;
        logic       setup1;
        logic       setup2;
        logic       setup3;
        logic       step;
        logic       single_load;
        logic [1:0] single_kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        act_t act;
        logic done_hit;
        logic run;
        logic out_free;
        logic step_ok;
        logic at_end;
    } sts_t;

endpackage

>>> design/sliding_window_sack_sender_core.sv
// Top level of the sliding-window sender with cumulative and selective ack.
// Instantiates swss_ctrl and swss_dp; depends on swss_pkg.
//
//  channel   direction  handshake              payload
//  in        request    in_valid / in_ready    op, ack_seq, sack_bits
//  out       result     out_valid / out_ready  kind, seq, last
//  cfg       write      cfg_wr_en              cfg_addr, cfg_wdata
//
// An ignored or duplicate-below-threshold event returns to idle straight from
// evaluation; a done (after the check) or failed result is loaded in the
// single-result state once the output is free. A burst goes from evaluation,
// via the check for a start or new ack, to SETUP1, SETUP2 and SETUP3, then
// walks one window slot per cycle (at most MAX_WINDOW), skipped ones included,
// unless a low out_ready holds it on a send slot; the walk sets the rate.
// Reset clears the window state and loads the configuration defaults at once;
// there is no clearing pass. A new request is taken once the previous one was
// ignored, ended its setup or slot walk, or loaded its single result.
module sliding_window_sack_sender_core #(
    parameter int MAX_WINDOW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] ack_seq,
    input  logic [31:0] sack_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] seq,
    output logic        last
);

    swss_pkg::cmd_t cmd;
    swss_pkg::sts_t sts;

    // Sequencer.
    swss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Window state, burst setup and result register.
    swss_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .ack_seq   (ack_seq),
        .sack_bits (sack_bits),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .seq       (seq),
        .last      (last)
    );

endmodule

>>> design/swss_ctrl.sv
// Sequencing state machine for the sliding-window sender.
// Depends on swss_pkg for the command and status structs.
module swss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  swss_pkg::sts_t   sts,
    output swss_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_RUN,
        ST_SINGLE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    // Next state and the kind of a pending done or failed result.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (sts.act)
                    swss_pkg::ACT_NONE:  state_next = ST_IDLE;
                    swss_pkg::ACT_BURST: state_next = ST_SETUP1;
                    swss_pkg::ACT_CHECK: state_next = ST_CHECK;
                    swss_pkg::ACT_FAIL:
                    begin
                        state_next = ST_SINGLE;
                        kind_next  = swss_pkg::KIND_FAILED;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (sts.done_hit)
                begin
                    state_next = ST_SINGLE;
                    kind_next  = swss_pkg::KIND_DONE;
                end
                else
                begin
                    state_next = ST_SETUP1;
                end
            end
            ST_SETUP1: state_next = ST_SETUP2;
            ST_SETUP2: state_next = ST_SETUP3;
            ST_SETUP3: state_next = sts.run ? ST_RUN : ST_IDLE;
            ST_RUN:
            begin
                if (sts.step_ok && sts.at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered kind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= swss_pkg::KIND_DONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Command decode from the current state.
    always_comb
    begin
        cmd             = '0;
        cmd.capture     = (state_reg == ST_IDLE) && in_valid;
        cmd.eval        = (state_reg == ST_EVAL);
        cmd.check       = (state_reg == ST_CHECK);
        cmd.setup1      = (state_reg == ST_SETUP1);
        cmd.setup2      = (state_reg == ST_SETUP2);
        cmd.setup3      = (state_reg == ST_SETUP3);
        cmd.step        = (state_reg == ST_RUN);
        cmd.single_load = (state_reg == ST_SINGLE) && sts.out_free;
        cmd.single_kind = kind_reg;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> design/swss_dp.sv
// Datapath of the sliding-window sender: configuration, window state,
// burst setup, slot walk and the output register. Depends on swss_pkg.
module swss_dp #(
    parameter int MAX_WINDOW = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [31:0]      cfg_wdata,
    input  logic [1:0]       op,
    input  logic [31:0]      ack_seq,
    input  logic [31:0]      sack_bits,
    input  swss_pkg::cmd_t   cmd,
    output swss_pkg::sts_t   sts,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      seq,
    output logic             last
);

    localparam int OFF_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Configuration registers.
    logic [5:0]  win_reg;
    logic [31:0] total_reg;
    logic [7:0]  max_to_reg;
    logic [7:0]  dup_thr_reg;

    // Captured request.
    logic [1:0]  ev_op_reg;
    logic [31:0] ev_ack_reg;
    logic [31:0] ev_sack_reg;

    // Window state.
    logic [31:0] nts_reg, nts_next;
    logic [31:0] cum_reg, cum_next;
    logic [31:0] sack_reg, sack_next;
    logic [7:0]  dup_reg, dup_next;
    logic [7:0]  to_reg, to_next;
    logic        fin_reg, fin_next;

    // Burst setup and walk.
    logic [31:0]           lim_reg, lim_next;
    logic [31:0]           s0_reg, s0_next;
    logic                  run_reg, run_next;
    logic [OFF_W-1:0]      start_reg, start_next;
    logic [OFF_W-1:0]      end_reg, end_next;
    logic [MAX_WINDOW-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]      d_reg, d_next;

    // Output register.
    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] seq_reg, seq_next;
    logic        last_reg, last_next;

    // Helpers.
    logic                  out_free;
    logic                  cur_emit;
    logic                  at_end;
    logic                  step_ok;
    logic                  load_send;
    logic [MAX_WINDOW-1:0] mask_rest;
    logic [7:0]            dup_inc;
    logic [7:0]            to_inc;
    logic [OFF_W-1:0]      w_eff;
    logic [32:0]           win_sum;
    logic [31:0]           sack_sh;
    swss_pkg::act_t        act;

    assign out_free  = !ov_reg || out_ready;
    assign cur_emit  = mask_reg[d_reg];
    assign at_end    = (OFF_W'(d_reg) + OFF_W'(1)) == end_reg;
    assign step_ok   = !cur_emit || out_free;
    assign load_send = cmd.step && cur_emit && out_free;
    assign dup_inc   = (dup_reg == 8'hFF) ? dup_reg : dup_reg + 8'd1;
    assign to_inc    = (to_reg == 8'hFF) ? to_reg : to_reg + 8'd1;
    assign sack_sh   = {sack_reg[30:0], 1'b0};

    // Remaining send slots once the current one is taken.
    always_comb
    begin
        mask_rest        = mask_reg;
        mask_rest[d_reg] = 1'b0;
    end

    // Window clamped to the range the walk supports.
    always_comb
    begin
        if (win_reg == 6'd0)
        begin
            w_eff = OFF_W'(1);
        end
        else if ({1'b0, win_reg} > 7'(MAX_WINDOW))
        begin
            w_eff = OFF_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = OFF_W'(win_reg);
        end
    end
    assign win_sum = {1'b0, cum_reg} + 33'(w_eff);

    // Follow-up work for the captured event under the current state.
    always_comb
    begin
        act = swss_pkg::ACT_NONE;
        unique case (ev_op_reg)
            swss_pkg::OP_START: act = swss_pkg::ACT_CHECK;
            swss_pkg::OP_ACK:
            begin
                if (!fin_reg)
                begin
                    if (ev_ack_reg != cum_reg)
                    begin
                        act = swss_pkg::ACT_CHECK;
                    end
                    else if (dup_inc >= dup_thr_reg)
                    begin
                        act = swss_pkg::ACT_BURST;
                    end
                end
            end
            swss_pkg::OP_TIMEOUT:
            begin
                if (!fin_reg)
                begin
                    act = (to_inc >= max_to_reg) ? swss_pkg::ACT_FAIL
                                                 : swss_pkg::ACT_BURST;
                end
            end
            default: act = swss_pkg::ACT_NONE;
        endcase
    end

    // Window state update.
    always_comb
    begin
        nts_next  = nts_reg;
        cum_next  = cum_reg;
        sack_next = sack_reg;
        dup_next  = dup_reg;
        to_next   = to_reg;
        fin_next  = fin_reg;
        if (cmd.eval)
        begin
            unique case (ev_op_reg)
                swss_pkg::OP_START:
                begin
                    nts_next  = '0;
                    cum_next  = '0;
                    sack_next = '0;
                    dup_next  = '0;
                    to_next   = '0;
                    fin_next  = 1'b0;
                end
                swss_pkg::OP_ACK:
                begin
                    if (!fin_reg)
                    begin
                        sack_next = ev_sack_reg;
                        if (ev_ack_reg != cum_reg)
                        begin
                            cum_next = ev_ack_reg;
                            dup_next = '0;
                            to_next  = '0;
                        end
                        else if (dup_inc >= dup_thr_reg)
                        begin
                            dup_next = '0;
                            nts_next = cum_reg;
                        end
                        else
                        begin
                            dup_next = dup_inc;
                        end
                    end
                end
                swss_pkg::OP_TIMEOUT:
                begin
                    if (!fin_reg)
                    begin
                        to_next = to_inc;
                        if (to_inc >= max_to_reg)
                        begin
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            dup_next = '0;
                            nts_next = cum_reg;
                        end
                    end
                end
                default: fin_next = fin_reg;
            endcase
        end
        else if (cmd.check && (cum_reg >= total_reg))
        begin
            fin_next = 1'b1;
        end
        else if (cmd.setup2)
        begin
            nts_next = (s0_reg < lim_reg) ? lim_reg : s0_reg;
        end
    end

    // Burst setup: limit and start point, then offsets, then the slot mask; also the slot walk.
    always_comb
    begin
        lim_next   = lim_reg;
        s0_next    = s0_reg;
        run_next   = run_reg;
        start_next = start_reg;
        end_next   = end_reg;
        mask_next  = mask_reg;
        d_next     = d_reg;
        if (cmd.setup1)
        begin
            lim_next = (win_sum > {1'b0, total_reg}) ? total_reg : win_sum[31:0];
            s0_next  = (nts_reg > cum_reg) ? nts_reg : cum_reg;
        end
        else if (cmd.setup2)
        begin
            run_next   = s0_reg < lim_reg;
            start_next = s0_reg[OFF_W-1:0] - cum_reg[OFF_W-1:0];
            end_next   = lim_reg[OFF_W-1:0] - cum_reg[OFF_W-1:0];
        end
        else if (cmd.setup3)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                mask_next[k] = (OFF_W'(k) >= start_reg) && (OFF_W'(k) < end_reg)
                               && !sack_sh[k];
            end
            d_next = start_reg[IDX_W-1:0];
        end
        else if (cmd.step && step_ok)
        begin
            mask_next = mask_rest;
            if (!at_end)
            begin
                d_next = d_reg + IDX_W'(1);
            end
        end
    end

    // Output register: one send slot or a single done or failed result.
    always_comb
    begin
        ov_next   = ov_reg && !out_ready;
        kind_next = kind_reg;
        seq_next  = seq_reg;
        last_next = last_reg;
        if (load_send)
        begin
            ov_next   = 1'b1;
            kind_next = swss_pkg::KIND_SEND;
            seq_next  = cum_reg + 32'(d_reg);
            last_next = (mask_rest == '0);
        end
        else if (cmd.single_load)
        begin
            ov_next   = 1'b1;
            kind_next = cmd.single_kind;
            seq_next  = '0;
            last_next = 1'b1;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= 6'd4;
            total_reg   <= 32'd1;
            max_to_reg  <= 8'd3;
            dup_thr_reg <= 8'd3;
            nts_reg     <= '0;
            cum_reg     <= '0;
            sack_reg    <= '0;
            dup_reg     <= '0;
            to_reg      <= '0;
            fin_reg     <= 1'b0;
            run_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    swss_pkg::REG_WINDOW:  win_reg     <= cfg_wdata[5:0];
                    swss_pkg::REG_TOTAL:   total_reg   <= cfg_wdata;
                    swss_pkg::REG_MAX_TO:  max_to_reg  <= cfg_wdata[7:0];
                    swss_pkg::REG_DUP_THR: dup_thr_reg <= cfg_wdata[7:0];
                endcase
            end
            nts_reg  <= nts_next;
            cum_reg  <= cum_next;
            sack_reg <= sack_next;
            dup_reg  <= dup_next;
            to_reg   <= to_next;
            fin_reg  <= fin_next;
            run_reg  <= run_next;
            ov_reg   <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_op_reg   <= op;
            ev_ack_reg  <= ack_seq;
            ev_sack_reg <= sack_bits;
        end
        lim_reg   <= lim_next;
        s0_reg    <= s0_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        mask_reg  <= mask_next;
        d_reg     <= d_next;
        kind_reg  <= kind_next;
        seq_reg   <= seq_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        sts          = '0;
        sts.act      = act;
        sts.done_hit = cum_reg >= total_reg;
        sts.run      = run_reg;
        sts.out_free = out_free;
        sts.step_ok  = step_ok;
        sts.at_end   = at_end;
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign seq       = seq_reg;
    assign last      = last_reg;

    // A waiting result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load_send || cmd.single_load) |-> (!ov_reg || out_ready))
        else $error("result register reloaded while a result was waiting");

    // A done or failed result leaves the transfer finished.
    a_end_finished: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.single_load |=> fin_reg)
        else $error("end result issued without the finished flag");

    // Every send command lies inside the window above the cumulative ack.
    a_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        load_send |-> ((32'(d_reg) < 32'(MAX_WINDOW)) && (OFF_W'(d_reg) < end_reg)))
        else $error("send command outside the window");

    // The slot walk only runs on a burst that has slots to visit.
    a_walk_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> run_reg)
        else $error("slot walk started on an empty burst");

endmodule
